>>> src/pas_pkg.sv
// Shared constants and operation codes for the priority aging scheduler.
package pas_pkg;

  localparam int NUM_SLOTS_DEF     = 8;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam int FUNC_W     = 2;
  localparam int ID_W       = 8;
  localparam int IN_PRIO_W  = 16;
  localparam int SLOT_OUT_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADMIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SETBASE = 2'd2;

endpackage

>>> src/pas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/pas_age_unit.sv
// Shared per-slot aging and best-priority compare unit.
module pas_age_unit #(
  parameter int PRIORITY_BITS = 16
) (
  input  logic [PRIORITY_BITS-1:0] prio,
  input  logic [PRIORITY_BITS-1:0] base,
  input  logic                     is_exec,
  input  logic [PRIORITY_BITS-1:0] best_prio,
  input  logic                     first,
  output logic [PRIORITY_BITS-1:0] new_prio,
  output logic                     take
);

  // executing slot falls back to base; ready slots age by one, saturating
  always_comb begin
    if (is_exec) begin
      new_prio = base;
    end else if (prio == '1) begin
      new_prio = prio;
    end else begin
      new_prio = prio + PRIORITY_BITS'(1);
    end
    take = first || (new_prio > best_prio);
  end

endmodule

>>> src/priority_aging_scheduler.sv
// Top level of the priority aging scheduler: sequencer, slot table and result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one request carries func, task_id and
//   priority_value. func is tick, admit task or set base priority.
//   Result channel (out_valid / out_stall): exactly one result per request.
//   Admit fills the next free slot (refused when full); set-base writes the
//   base priority of the lowest slot holding task_id, or slot 0 if none.
//   A tick ages every ready slot, drops the executing slot to its base and
//   picks the strictly highest priority, lowest slot on ties.
// Sequencing:
//   Tick and set-base walk the occupied slots through one shared age/compare
//   unit, one slot per cycle behind the registered table read; set-base stops
//   walking at its first match. Admit and unused codes go straight to the
//   result. One request is in flight at a time; in_stall is high until the
//   sequencer is idle again, so a new request is not taken before the last
//   result is loaded. The block may take the next request while a result
//   still sits in the output register.
// Reset clears the slot count, the executing mark and both channels; table
// entries at or above the count are never read. A stalled result holds.
module priority_aging_scheduler #(
  parameter int NUM_SLOTS     = pas_pkg::NUM_SLOTS_DEF,
  parameter int PRIORITY_BITS = pas_pkg::PRIORITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pas_pkg::FUNC_W-1:0]        in_func,
  input  logic [pas_pkg::ID_W-1:0]          in_task_id,
  input  logic [pas_pkg::IN_PRIO_W-1:0]     in_priority_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pas_pkg::SLOT_OUT_W-1:0]    out_chosen_slot,
  output logic [pas_pkg::ID_W-1:0]          out_chosen_id,
  output logic [pas_pkg::SLOT_OUT_W-1:0]    out_previous_slot,
  output logic                              out_accepted
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int PB    = PRIORITY_BITS;
  localparam int ID_W  = pas_pkg::ID_W;
  localparam int SO_W  = pas_pkg::SLOT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // control
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      exec_v_r, exec_v_nxt;
  logic                      pv_r, pv_nxt;      // a table read is in flight
  logic                      found_r, found_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // payload
  logic [CNT_W-1:0]          idx_r, idx_nxt;    // next slot to read
  logic [IDX_W-1:0]          pidx_r, pidx_nxt;  // slot whose data is on the read port
  logic [pas_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [ID_W-1:0]           id_r, id_nxt;
  logic [PB-1:0]             val_r, val_nxt;
  logic [IDX_W-1:0]          exec_r, exec_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic [PB-1:0]             best_prio_r, best_prio_nxt;
  logic [IDX_W-1:0]          best_r, best_nxt;
  logic [ID_W-1:0]           best_id_r, best_id_nxt;
  logic [SO_W-1:0]           res_slot_r, res_slot_nxt;
  logic [ID_W-1:0]           res_id_r, res_id_nxt;
  logic [SO_W-1:0]           res_prev_r, res_prev_nxt;
  logic                      res_acc_r, res_acc_nxt;
  logic [SO_W-1:0]           out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]           out_id_r, out_id_nxt;
  logic [SO_W-1:0]           out_prev_r, out_prev_nxt;
  logic                      out_acc_r, out_acc_nxt;

  logic accept, full, is_tick, issue, finish, admit_we, out_load;
  logic [IDX_W-1:0] cnt_idx, rd_addr;

  logic             prio_we, base_we;
  logic [IDX_W-1:0] prio_wa, base_wa;
  logic [PB-1:0]    prio_wd, base_wd;
  logic [PB-1:0]    prio_rd, base_rd;
  logic [ID_W-1:0]  id_rd;
  logic [PB-1:0]    new_prio;
  logic             take;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(NUM_SLOTS));
  assign cnt_idx  = count_r[IDX_W-1:0];
  assign rd_addr  = idx_r[IDX_W-1:0];
  assign is_tick  = (func_r == pas_pkg::FUNC_TICK);
  // set-base stops reading once it has its match
  assign issue    = (state_r == S_WALK) && (idx_r < count_r) && !found_r;
  assign finish   = (state_r == S_WALK) && !pv_r && !issue;
  assign admit_we = accept && (in_func == pas_pkg::FUNC_ADMIT) && !full;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // table write ports
  assign prio_we = admit_we || (pv_r && is_tick);
  assign prio_wa = pv_r ? pidx_r : cnt_idx;
  assign prio_wd = pv_r ? new_prio : PB'(in_priority_value);

  assign base_we = admit_we || (finish && (func_r == pas_pkg::FUNC_SETBASE));
  assign base_wa = admit_we ? cnt_idx : (found_r ? pos_r : '0);
  assign base_wd = admit_we ? '0 : val_r;

  pas_ram #(.WIDTH(PB), .DEPTH(NUM_SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_wa),
    .wdata (prio_wd),
    .raddr (rd_addr),
    .rdata (prio_rd)
  );

  pas_ram #(.WIDTH(PB), .DEPTH(NUM_SLOTS)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_wa),
    .wdata (base_wd),
    .raddr (rd_addr),
    .rdata (base_rd)
  );

  pas_ram #(.WIDTH(ID_W), .DEPTH(NUM_SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (admit_we),
    .waddr (cnt_idx),
    .wdata (in_task_id),
    .raddr (rd_addr),
    .rdata (id_rd)
  );

  pas_age_unit #(.PRIORITY_BITS(PB)) u_age (
    .prio      (prio_rd),
    .base      (base_rd),
    .is_exec   (exec_v_r && (exec_r == pidx_r)),
    .best_prio (best_prio_r),
    .first     (pidx_r == '0),
    .new_prio  (new_prio),
    .take      (take)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    exec_v_nxt    = exec_v_r;
    pv_nxt        = pv_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    func_nxt      = func_r;
    id_nxt        = id_r;
    val_nxt       = val_r;
    exec_nxt      = exec_r;
    pos_nxt       = pos_r;
    best_prio_nxt = best_prio_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    res_slot_nxt  = res_slot_r;
    res_id_nxt    = res_id_r;
    res_prev_nxt  = res_prev_r;
    res_acc_nxt   = res_acc_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt      = in_func;
          id_nxt        = in_task_id;
          val_nxt       = PB'(in_priority_value);
          res_slot_nxt  = '0;
          res_id_nxt    = '0;
          res_prev_nxt  = '0;
          res_acc_nxt   = 1'b0;
          idx_nxt       = '0;
          pv_nxt        = 1'b0;
          found_nxt     = 1'b0;
          best_prio_nxt = '0;
          best_nxt      = '0;
          best_id_nxt   = '0;
          case (in_func)
            pas_pkg::FUNC_TICK, pas_pkg::FUNC_SETBASE: begin
              state_nxt = S_WALK;
            end
            pas_pkg::FUNC_ADMIT: begin
              res_acc_nxt = !full;
              if (!full) begin
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;   // unused code: no effect, zero result
            end
          endcase
        end
      end
      S_WALK: begin
        pv_nxt = issue;
        if (issue) begin
          idx_nxt  = idx_r + CNT_W'(1);
          pidx_nxt = rd_addr;
        end
        if (pv_r) begin
          if (is_tick) begin
            if (take) begin
              best_prio_nxt = new_prio;
              best_nxt      = pidx_r;
              best_id_nxt   = id_rd;
            end
          end else if (!found_r && (id_rd == id_r)) begin
            found_nxt = 1'b1;
            pos_nxt   = pidx_r;
          end
        end
        if (finish) begin
          state_nxt = S_DONE;
          if (is_tick) begin
            res_slot_nxt = SO_W'(best_r);
            res_id_nxt   = best_id_r;
            res_prev_nxt = exec_v_r ? SO_W'(exec_r) : '0;
            exec_nxt     = best_r;
            exec_v_nxt   = (count_r != '0);
          end else begin
            res_acc_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_id_nxt    = out_id_r;
    out_prev_nxt  = out_prev_r;
    out_acc_nxt   = out_acc_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = res_slot_r;
      out_id_nxt    = res_id_r;
      out_prev_nxt  = res_prev_r;
      out_acc_nxt   = res_acc_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      exec_v_r    <= 1'b0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      exec_v_r    <= exec_v_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    func_r      <= func_nxt;
    id_r        <= id_nxt;
    val_r       <= val_nxt;
    exec_r      <= exec_nxt;
    pos_r       <= pos_nxt;
    best_prio_r <= best_prio_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    res_slot_r  <= res_slot_nxt;
    res_id_r    <= res_id_nxt;
    res_prev_r  <= res_prev_nxt;
    res_acc_r   <= res_acc_nxt;
    out_slot_r  <= out_slot_nxt;
    out_id_r    <= out_id_nxt;
    out_prev_r  <= out_prev_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_slot   = out_slot_r;
  assign out_chosen_id     = out_id_r;
  assign out_previous_slot = out_prev_r;
  assign out_accepted      = out_acc_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_SLOTS))
    else $error("slot count beyond table size");

  a_exec_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    exec_v_r |-> (CNT_W'(exec_r) < count_r))
    else $error("executing slot outside occupied range");

  a_admit_count: assert property (@(posedge clk) disable iff (!rst_n)
    admit_we |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("admit did not advance slot count");

  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_WALK))
    else $error("table read in flight outside walk");

  a_tick_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && is_tick) |=> (exec_v_r == ($past(count_r) != '0)))
    else $error("tick left wrong executing mark");

endmodule
